// ----- hw/rtl/sil_pkg.sv -----
// ----------------------------------------------------------------------------
// sil_pkg: shared types and constants for the sorted insert list
// Request codes, result status codes, the back-end state type and the
// request record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int unsigned DATA_W = 32;
  // Depth of the request queue between the front end and the back end.
  localparam int unsigned QDEPTH = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_ELEMENT  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DUMP = 1'b1
  } back_state_t;

  typedef struct packed {
    opcode_t                   op;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage

// ----- hw/rtl/sil_front.sv -----
// ----------------------------------------------------------------------------
// sil_front: request intake
// Registers each accepted request, classifies it and pushes it into the
// request queue.
// ----------------------------------------------------------------------------
module sil_front import sil_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic                      q_full,
  output logic                      q_push,
  output cmd_t                      q_push_cmd
);

  logic fr_valid_r;
  logic fr_valid_nxt;
  cmd_t fr_cmd_r;
  logic load;

  assign in_stall   = fr_valid_r && q_full;
  assign load       = in_valid && !in_stall;
  assign q_push     = fr_valid_r && !q_full;
  assign q_push_cmd = fr_cmd_r;

  always_comb begin
    fr_valid_nxt = load || (fr_valid_r && !q_push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  // The value field carries no meaning on a read-out, so it is zeroed.
  always_ff @(posedge clk) begin
    if (load) begin
      fr_cmd_r.op <= opcode_t'(in_opcode);
      if (opcode_t'(in_opcode) == OP_DUMP) begin
        fr_cmd_r.value <= '0;
      end else begin
        fr_cmd_r.value <= in_value;
      end
    end
  end

endmodule

// ----- hw/rtl/sil_queue.sv -----
// ----------------------------------------------------------------------------
// sil_queue: request queue
// A short first-in first-out queue that decouples intake from execution.
// ----------------------------------------------------------------------------
module sil_queue import sil_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head_cmd
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(QDEPTH));
  assign avail    = (cnt_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/sil_back.sv -----
// ----------------------------------------------------------------------------
// sil_back: sorted store and result stage
// A row of compare cells inserts a value in place; a read-out walks the store
// one entry per cycle into the output register, unless out_stall holds it.
// ----------------------------------------------------------------------------
module sil_back import sil_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_avail,
  input  cmd_t                      q_head_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_item,
  output logic [1:0]                out_status,
  output logic                      out_last
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  back_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] store_r [CAPACITY];
  logic signed [DATA_W-1:0] store_nxt [CAPACITY];
  logic                     ins_at [CAPACITY];
  logic                     do_insert;
  logic                     can_load;
  logic                     store_full;
  logic                     valid_r, valid_nxt;
  logic signed [DATA_W-1:0] item_r, item_nxt;
  status_t                  status_r, status_nxt;
  logic                     last_r, last_nxt;
  logic                     dump_last;

  assign can_load   = !valid_r || !out_stall;
  assign q_pop      = (state_r == BK_IDLE) && q_avail && can_load;
  assign store_full = (count_r == CNT_W'(CAPACITY));
  assign do_insert  = q_pop && (q_head_cmd.op == OP_INSERT) && !store_full;
  assign dump_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign out_valid  = valid_r;
  assign out_item   = item_r;
  assign out_status = status_r;
  assign out_last   = last_r;

  // Each cell asks whether the new value goes at or before it. Unused cells
  // answer yes, so the answers are monotonic along the row.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins_at[i] = (CNT_W'(i) >= count_r) || (store_r[i] >= q_head_cmd.value);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (i > 0 && ins_at[(i > 0) ? i - 1 : 0]) begin
        store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
      end else if (ins_at[i]) begin
        store_nxt[i] = q_head_cmd.value;
      end else begin
        store_nxt[i] = store_r[i];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop && q_head_cmd.op == OP_DUMP && count_r > CNT_W'(1)) begin
          state_nxt = BK_DUMP;
        end
      end
      BK_DUMP: begin
        if (can_load && dump_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r && out_stall;
    item_nxt   = item_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          valid_nxt = 1'b1;
          if (q_head_cmd.op == OP_INSERT) begin
            item_nxt = q_head_cmd.value;
            last_nxt = 1'b1;
            if (store_full) begin
              status_nxt = ST_DROPPED;
            end else begin
              status_nxt = ST_INSERTED;
              count_nxt  = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            item_nxt   = '0;
            status_nxt = ST_EMPTY;
            last_nxt   = 1'b1;
          end else begin
            item_nxt   = store_r[0];
            status_nxt = ST_ELEMENT;
            last_nxt   = (count_r == CNT_W'(1));
            idx_nxt    = IDX_W'(1);
          end
        end
      end
      BK_DUMP: begin
        if (can_load) begin
          valid_nxt  = 1'b1;
          item_nxt   = store_r[idx_r];
          status_nxt = ST_ELEMENT;
          last_nxt   = dump_last;
          idx_nxt    = idx_r + IDX_W'(1);
        end
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
    if (do_insert) begin
      for (int i = 0; i < CAPACITY; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DUMP |-> CNT_W'(idx_r) < count_r)
    else $error("read-out index past the stored entries");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> store_r[0] <= store_r[1])
    else $error("first two entries out of order");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the store");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head_cmd.op == OP_INSERT && store_full |=> count_r == CNT_W'(CAPACITY))
    else $error("dropped insert changed the entry count");
`endif

endmodule

// ----- hw/rtl/sorted_insert_list.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_list: bounded store of signed values kept in ascending order
// Inserts values ahead of the first equal or greater entry and streams the
// whole store out in order on request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      in         in_valid / in_stall   in_opcode, in_value
//   out_     out        out_valid / out_stall out_item, out_status, out_last
//
// An insert request gives a single result and a read-out one result per stored
// entry (one on an empty store); the output register takes one result per cycle
// unless out_stall holds it. A request passes the intake register, then the
// queue, then the output register.
// Reset is synchronous and active low; it clears the entry count and the queue.
// A result-side stall holds the output register and fills the queue, then
// in_stall rises.
//
module sorted_insert_list import sil_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic signed [DATA_W-1:0]  in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_item,
  output logic [1:0]                out_status,
  output logic                      out_last
);

  // Requests travel from intake to execution as one record.
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_avail;
  cmd_t q_head_cmd;

  // The front end registers and classifies each request. Read-out requests
  // lose their value field here so that nothing downstream depends on it.
  sil_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_value   (in_value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_cmd (q_push_cmd)
  );

  // The queue lets intake continue while a long read-out is streaming.
  sil_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_cmd (q_head_cmd)
  );

  // The back end owns the sorted store and the output register. Requests
  // are executed strictly in order, so a read-out always reflects every
  // insert accepted ahead of it.
  sil_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_avail    (q_avail),
    .q_head_cmd (q_head_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the sorted insert list
// A queue of requests (a short directed opening, then a random mix of inserts
// and read-outs) feeds a clocked driver. A clocked monitor compares every
// result against a mirror of the sorted store kept inside the bench. Both
// channels idle and stall at random, with one long result-side hold-off and
// one point where the sender waits for every outstanding result.
// ----------------------------------------------------------------------------
module tb;
  import sil_pkg::*;

  localparam int CAP        = 16;
  localparam int N_RANDOM   = 248;
  localparam int CYC_LIMIT  = 200000;
  localparam int QUIET_LO   = 600;   // cycles in [QUIET_LO, QUIET_HI) have no idling
  localparam int QUIET_HI   = 1400;
  localparam int HOLD_AFTER = 40;    // results seen before the long hold-off starts
  localparam int HOLD_LEN   = 100;
  localparam int TAIL_CYC   = 20;

  typedef struct {
    opcode_t                  op;
    logic signed [DATA_W-1:0] value;
    bit                       drain;  // sender waits for all results first
  } request_t;

  typedef struct {
    logic signed [DATA_W-1:0] item;
    status_t                  status;
    logic                     last;
  } list_out_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic                     in_opcode  = OP_INSERT;
  logic signed [DATA_W-1:0] in_value   = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic signed [DATA_W-1:0] out_item;
  logic [1:0]               out_status;
  logic                     out_last;

  request_t  request_q[$];
  list_out_t awaited_list_out[$];

  // Mirror of the block's sorted store, advanced once per accepted request.
  logic signed [DATA_W-1:0] mirror_list [CAP];
  int                       mirror_count = 0;

  int mismatch_cnt = 0;
  int results_seen = 0;
  int cyc          = 0;

  sorted_insert_list #(.CAPACITY(CAP)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always #5 clk = ~clk;

  // Works out the results of one accepted request and queues them.
  // An insert goes ahead of the first stored value that is greater than or
  // equal to it; a full store drops the value. A read-out lists the store in
  // order, or gives a single empty marker when nothing is stored.
  function automatic void apply_list_request(opcode_t op, logic signed [DATA_W-1:0] v);
    int pos;
    if (op == OP_INSERT) begin
      if (mirror_count >= CAP) begin
        awaited_list_out.push_back('{item: v, status: ST_DROPPED, last: 1'b1});
      end else begin
        pos = 0;
        while (pos < mirror_count && mirror_list[pos] < v) pos++;
        for (int i = mirror_count; i > pos; i--) mirror_list[i] = mirror_list[i-1];
        mirror_list[pos] = v;
        mirror_count++;
        awaited_list_out.push_back('{item: v, status: ST_INSERTED, last: 1'b1});
      end
    end else if (mirror_count == 0) begin
      awaited_list_out.push_back('{item: '0, status: ST_EMPTY, last: 1'b1});
    end else begin
      for (int i = 0; i < mirror_count; i++)
        awaited_list_out.push_back('{item: mirror_list[i], status: ST_ELEMENT,
                                     last: (i == mirror_count - 1)});
    end
  endfunction

  function automatic bit in_quiet_window();
    return (cyc >= QUIET_LO) && (cyc < QUIET_HI);
  endfunction

  // Run-length guard.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Driver. A request is taken at an edge where in_valid is high and in_stall
  // is low; the mirror is updated right there. A stalled request is held
  // unchanged, otherwise the next one is offered unless the sender idles or
  // a drain point makes it wait for the results still outstanding.
  always @(posedge clk) begin : drive_proc
    request_t req;
    bit       idle;
    bit       draining;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        apply_list_request(opcode_t'(in_opcode), in_value);
      if (!(in_valid && in_stall)) begin
        idle     = !in_quiet_window() && ($urandom_range(99) < 18);
        draining = (request_q.size() != 0) && request_q[0].drain &&
                   (awaited_list_out.size() != 0);
        if (request_q.size() != 0 && !idle && !draining) begin
          req = request_q.pop_front();
          in_valid  <= 1'b1;
          in_opcode <= req.op;
          in_value  <= req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted result is checked field by field against the
  // oldest awaited one. The receiver stalls at random, never inside the quiet
  // window, and once holds off for a long stretch so that the request queue
  // inside the block fills and in_stall has to rise.
  always @(posedge clk) begin : monitor_proc
    list_out_t want;
    int        hold_left;
    bit        hold_done;
    int        errs;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        errs = 0;
        if (awaited_list_out.size() == 0) begin
          $display("%0t: result with none awaited: item %0d status %0d last %0d",
                   $time, out_item, out_status, out_last);
          errs++;
        end else begin
          want = awaited_list_out.pop_front();
          if (out_item !== want.item) begin
            $display("%0t: item expected %0d actual %0d", $time, want.item, out_item);
            errs++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_status);
            errs++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
            errs++;
          end
        end
        if (errs != 0)
          mismatch_cnt <= mismatch_cnt + errs;
      end
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !in_quiet_window() && ($urandom_range(99) < 18);
      end
    end
  end

  task automatic add_request(opcode_t op, logic signed [DATA_W-1:0] v, bit drain = 1'b0);
    request_q.push_back('{op: op, value: v, drain: drain});
  endtask

  initial begin : stimulus_proc
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] used_vals[$];
    int                       pick;
    opcode_t                  op;

    // Directed opening: read-out of the empty store, the extremes of the
    // value range, ties at the bottom, middle and top, and read-outs of a
    // partly filled store.
    add_request(OP_DUMP,   32'sh7FFF_FFFF);
    add_request(OP_INSERT, 32'sh8000_0000);
    add_request(OP_INSERT, 32'sh7FFF_FFFF);
    add_request(OP_INSERT, 32'sh0000_0000);
    add_request(OP_INSERT, 32'sh0000_0000);
    add_request(OP_INSERT, -32'sd1);
    add_request(OP_INSERT, 32'sd1);
    add_request(OP_DUMP,   32'sh8000_0000);
    add_request(OP_INSERT, 32'sh8000_0000);
    add_request(OP_INSERT, 32'sh7FFF_FFFF);
    add_request(OP_DUMP,   32'sh5555_AAAA);
    used_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1};

    // Random part. The store never shrinks, so the first few inserts finish
    // filling it with a mix of wide, narrow and repeated values; after that
    // inserts are dropped and read-outs return the full sorted list.
    for (int n = 0; n < N_RANDOM; n++) begin
      op   = ($urandom_range(99) < 25) ? OP_DUMP : OP_INSERT;
      pick = $urandom_range(99);
      if (pick < 40)      v = $urandom;
      else if (pick < 60) v = int'($urandom_range(20)) - 10;
      else if (pick < 75) v = used_vals[$urandom_range(used_vals.size() - 1)];
      else if (pick < 85) begin
        case ($urandom_range(3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7FFF_FFFF;
          2:       v = 32'sh0;
          default: v = -32'sd1;
        endcase
      end else begin
        v = 32'sd1 << $urandom_range(31);
        if ($urandom_range(1)) v = ~v;
      end
      if (op == OP_INSERT) used_vals.push_back(v);
      // Partway through, the sender lets the block drain completely.
      add_request(op, v, n == N_RANDOM / 2);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every result to come back.
    while (request_q.size() != 0 || in_valid || awaited_list_out.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (mismatch_cnt == 0 && awaited_list_out.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
